// ===== src/pnghdr_pkg.sv =====
package pnghdr_pkg;

  typedef enum logic [2:0] {
    PH_SIG  = 3'd0,
    PH_LEN  = 3'd1,
    PH_TYPE = 3'd2,
    PH_IHDR = 3'd3,
    PH_SKIP = 3'd4,
    PH_DONE = 3'd5
  } phase_e;

  typedef logic [1:0] status_t;

  localparam status_t ST_OK        = 2'd0;
  localparam status_t ST_BAD_SIG   = 2'd1;
  localparam status_t ST_BAD_IHDR  = 2'd2;
  localparam status_t ST_NOT_FOUND = 2'd3;

  localparam logic [31:0] TYPE_IHDR = 32'h4948_4452;
  localparam logic [31:0] IHDR_LEN  = 32'd13;
  localparam logic [32:0] CRC_BYTES = 33'd4;
  localparam logic [3:0]  IHDR_LAST = 4'd12;
  localparam logic [3:0]  SIG_LAST  = 4'd7;
  localparam logic [3:0]  WORD_LAST = 4'd3;
  localparam logic [3:0]  WIDTH_END = 4'd4;
  localparam logic [3:0]  HEIGHT_END = 4'd8;

  localparam int OUT_TDATA_W = 104;

  function automatic logic [7:0] sig_byte(input logic [2:0] idx);
    logic [7:0] b;
    unique case (idx)
      3'd0: b = 8'd137;
      3'd1: b = 8'd80;
      3'd2: b = 8'd78;
      3'd3: b = 8'd71;
      3'd4: b = 8'd13;
      3'd5: b = 8'd10;
      3'd6: b = 8'd26;
      3'd7: b = 8'd10;
      default: b = 8'd0;
    endcase
    return b;
  endfunction

endpackage

// ===== src/png_header_dimension_parser_unit.sv =====
// PNG IHDR parser: takes a PNG file one byte per transaction, checks the
// 8-byte signature, walks chunks (big-endian length, type, skipping data
// and CRC of chunks other than IHDR) and extracts the raw width and height
// from IHDR. One result leaves on the byte marked tlast: status (0 ok,
// 1 bad signature, 2 invalid IHDR, 3 IHDR not found), width and height
// (zero unless ok) and the byte count of the file, saturated. The block
// takes one byte every cycle; per-byte work is a single pass from the
// parser state registers into the state and result registers. Only a byte
// marked tlast waits, and only while the previous result is still held in
// the output register and not taken in that cycle. After the last byte
// the parser is back in its reset state for the next file.
module png_header_dimension_parser_unit #(
  parameter int COUNT_BITS = 32
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_axis_tvalid_i,
  output logic                                s_axis_tready_o,
  // [7:0] data_byte
  input  logic [7:0]                          s_axis_tdata_i,
  input  logic                                s_axis_tlast_i,
  output logic                                m_axis_tvalid_o,
  input  logic                                m_axis_tready_i,
  // [1:0] status, [33:2] width, [65:34] height, [97:66] stream_bytes,
  // [103:98] zero
  output logic [pnghdr_pkg::OUT_TDATA_W-1:0]  m_axis_tdata_o
);

  pnghdr_pkg::phase_e phase_q, phase_d;
  logic [3:0]              cnt_q, cnt_d;
  logic [31:0]             len_q, len_d;
  logic [31:0]             type_q, type_d;
  logic [32:0]             skip_q, skip_d;
  logic [31:0]             width_q, width_d;
  logic [31:0]             height_q, height_d;
  logic [COUNT_BITS-1:0]   total_q, total_d;
  pnghdr_pkg::status_t     fstat_q, fstat_d;

  logic                    out_valid_q;
  pnghdr_pkg::status_t     res_status_q, res_status;
  logic [31:0]             res_width_q, res_height_q, res_bytes_q, bytes_sat;

  logic in_accept;
  logic [32:0] skip_dec;

  assign s_axis_tready_o = !out_valid_q || m_axis_tready_i || !s_axis_tlast_i;
  assign in_accept = s_axis_tvalid_i && s_axis_tready_o;
  assign skip_dec  = skip_q - {32'd0, (skip_q != 33'd0)};

  // next phase
  always_comb begin
    phase_d = phase_q;
    unique case (phase_q)
      pnghdr_pkg::PH_SIG: begin
        if (s_axis_tdata_i != pnghdr_pkg::sig_byte(cnt_q[2:0])) begin
          phase_d = pnghdr_pkg::PH_DONE;
        end else if (cnt_q >= pnghdr_pkg::SIG_LAST) begin
          phase_d = pnghdr_pkg::PH_LEN;
        end
      end
      pnghdr_pkg::PH_LEN: begin
        if (cnt_q >= pnghdr_pkg::WORD_LAST) phase_d = pnghdr_pkg::PH_TYPE;
      end
      pnghdr_pkg::PH_TYPE: begin
        if (cnt_q >= pnghdr_pkg::WORD_LAST) begin
          if (type_d != pnghdr_pkg::TYPE_IHDR) begin
            phase_d = pnghdr_pkg::PH_SKIP;
          end else if (len_q != pnghdr_pkg::IHDR_LEN) begin
            phase_d = pnghdr_pkg::PH_DONE;
          end else begin
            phase_d = pnghdr_pkg::PH_IHDR;
          end
        end
      end
      pnghdr_pkg::PH_IHDR: begin
        if (cnt_q >= pnghdr_pkg::IHDR_LAST) phase_d = pnghdr_pkg::PH_DONE;
      end
      pnghdr_pkg::PH_SKIP: begin
        if (skip_dec == 33'd0) phase_d = pnghdr_pkg::PH_LEN;
      end
      pnghdr_pkg::PH_DONE: phase_d = pnghdr_pkg::PH_DONE;
      default: phase_d = pnghdr_pkg::PH_SIG;
    endcase
  end

  // field datapath
  always_comb begin
    cnt_d    = cnt_q;
    len_d    = len_q;
    type_d   = type_q;
    skip_d   = skip_q;
    width_d  = width_q;
    height_d = height_q;
    fstat_d  = fstat_q;
    total_d  = (&total_q) ? total_q : total_q + {{(COUNT_BITS-1){1'b0}}, 1'b1};
    unique case (phase_q)
      pnghdr_pkg::PH_SIG: begin
        if (s_axis_tdata_i != pnghdr_pkg::sig_byte(cnt_q[2:0])) begin
          fstat_d = pnghdr_pkg::ST_BAD_SIG;
        end else if (cnt_q >= pnghdr_pkg::SIG_LAST) begin
          cnt_d = 4'd0;
        end else begin
          cnt_d = cnt_q + 4'd1;
        end
      end
      pnghdr_pkg::PH_LEN: begin
        len_d = {len_q[23:0], s_axis_tdata_i};
        cnt_d = (cnt_q >= pnghdr_pkg::WORD_LAST) ? 4'd0 : cnt_q + 4'd1;
      end
      pnghdr_pkg::PH_TYPE: begin
        type_d = {type_q[23:0], s_axis_tdata_i};
        cnt_d  = (cnt_q >= pnghdr_pkg::WORD_LAST) ? 4'd0 : cnt_q + 4'd1;
        if (cnt_q >= pnghdr_pkg::WORD_LAST) begin
          if (type_d != pnghdr_pkg::TYPE_IHDR) begin
            skip_d = {1'b0, len_q} + pnghdr_pkg::CRC_BYTES;
          end else if (len_q != pnghdr_pkg::IHDR_LEN) begin
            fstat_d = pnghdr_pkg::ST_BAD_IHDR;
          end
        end
      end
      pnghdr_pkg::PH_IHDR: begin
        if (cnt_q < pnghdr_pkg::WIDTH_END) begin
          width_d = {width_q[23:0], s_axis_tdata_i};
        end else if (cnt_q < pnghdr_pkg::HEIGHT_END) begin
          height_d = {height_q[23:0], s_axis_tdata_i};
        end
        if (cnt_q >= pnghdr_pkg::IHDR_LAST) begin
          fstat_d = pnghdr_pkg::ST_OK;
        end else begin
          cnt_d = cnt_q + 4'd1;
        end
      end
      pnghdr_pkg::PH_SKIP: begin
        skip_d = skip_dec;
        if (skip_dec == 33'd0) cnt_d = 4'd0;
      end
      default: ;
    endcase
  end

  // result of a file that ends on this byte
  always_comb begin
    unique case (phase_d)
      pnghdr_pkg::PH_SIG:  res_status = pnghdr_pkg::ST_BAD_SIG;
      pnghdr_pkg::PH_IHDR: res_status = pnghdr_pkg::ST_BAD_IHDR;
      pnghdr_pkg::PH_DONE: res_status = fstat_d;
      default:             res_status = pnghdr_pkg::ST_NOT_FOUND;
    endcase
  end

  generate
    if (COUNT_BITS > 32) begin : g_sat_wide
      assign bytes_sat = (|total_d[COUNT_BITS-1:32]) ? 32'hFFFF_FFFF : total_d[31:0];
    end else if (COUNT_BITS == 32) begin : g_sat_eq
      assign bytes_sat = total_d;
    end else begin : g_sat_narrow
      assign bytes_sat = {{(32-COUNT_BITS){1'b0}}, total_d};
    end
  endgenerate

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= pnghdr_pkg::PH_SIG;
      cnt_q    <= 4'd0;
      len_q    <= 32'd0;
      type_q   <= 32'd0;
      skip_q   <= 33'd0;
      width_q  <= 32'd0;
      height_q <= 32'd0;
      total_q  <= '0;
      fstat_q  <= pnghdr_pkg::ST_NOT_FOUND;
    end else if (in_accept) begin
      if (s_axis_tlast_i) begin
        // file done: return to reset state
        phase_q  <= pnghdr_pkg::PH_SIG;
        cnt_q    <= 4'd0;
        len_q    <= 32'd0;
        type_q   <= 32'd0;
        skip_q   <= 33'd0;
        width_q  <= 32'd0;
        height_q <= 32'd0;
        total_q  <= '0;
        fstat_q  <= pnghdr_pkg::ST_NOT_FOUND;
      end else begin
        phase_q  <= phase_d;
        cnt_q    <= cnt_d;
        len_q    <= len_d;
        type_q   <= type_d;
        skip_q   <= skip_d;
        width_q  <= width_d;
        height_q <= height_d;
        total_q  <= total_d;
        fstat_q  <= fstat_d;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_accept && s_axis_tlast_i) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept && s_axis_tlast_i) begin
      res_status_q <= res_status;
      res_width_q  <= (res_status == pnghdr_pkg::ST_OK) ? width_d : 32'd0;
      res_height_q <= (res_status == pnghdr_pkg::ST_OK) ? height_d : 32'd0;
      res_bytes_q  <= bytes_sat;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {6'd0, res_bytes_q, res_height_q, res_width_q, res_status_q};

endmodule
